// ===== sv/tiled_grid_triangle_interpolator_assert.svh =====
// Assertion macros for the tiled grid triangle interpolator
`ifndef TILED_GRID_TRIANGLE_INTERPOLATOR_ASSERT_SVH
`define TILED_GRID_TRIANGLE_INTERPOLATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// check a property on every clock edge outside reset
`define TGTI_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tgti assertion failed");
// check a property on every clock edge, reset included
`define TGTI_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("tgti assertion failed");
`else
`define TGTI_ASSERT(label, prop)
`define TGTI_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== sv/tgti_pkg.sv =====
// Package: constants and codes of the tiled grid triangle interpolator
package tgti_pkg;

  localparam int unsigned WORLDS      = 2;
  localparam int unsigned MAX_SQUARES = 4096;
  localparam int unsigned MAX_CELLS   = 256;
  localparam int unsigned CELL_SIZE   = 1089;
  localparam int unsigned HALF_SIDE   = 17;
  localparam int unsigned BANK_CELL   = HALF_SIDE * HALF_SIDE;
  localparam int unsigned MAP_DEPTH   = WORLDS * MAX_SQUARES;
  localparam int unsigned BANK_DEPTH  = WORLDS * MAX_CELLS * BANK_CELL;
  localparam int unsigned SAMPLE_LIMIT = MAX_CELLS * CELL_SIZE;
  localparam int unsigned MAP_AW      = $clog2(MAP_DEPTH);
  localparam int unsigned BANK_AW     = $clog2(BANK_DEPTH);
  localparam int unsigned BANKS       = 4;

  // reciprocals for splitting a sample index into slot, row and column
  localparam int unsigned RECIP_CELL = 3851;  // floor(2^22 / 1089)
  localparam int unsigned RECIP_SIDE = 1985;  // floor(2^16 / 33)

  // pipeline depth ahead of the result register
  localparam int unsigned LATENCY = 8;

  localparam logic [1:0] ACT_QUERY  = 2'd0;
  localparam logic [1:0] ACT_MAP    = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_READY = 3'd1;
  localparam logic [2:0] ST_OUTSIDE   = 3'd2;
  localparam logic [2:0] ST_NO_CELL   = 3'd3;
  localparam logic [2:0] ST_REJECT    = 3'd4;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_WIDTH    = 2'd2;
  localparam logic [1:0] REG_HEIGHT   = 2'd3;

endpackage

// ===== sv/tiled_grid_triangle_interpolator.sv =====
// Top level: tiled grid sampler with triangle interpolation, eight-stage pipeline
//
//  channel   direction  handshake              payload
//  request   in         start & !busy          action_i world_i pos_x_i pos_y_i
//                                              load_address_i load_value_i
//  result    out        valid_o, one cycle     found_o temperature_o status_o
//  config    in         cfg_we_i               cfg_index_i cfg_wdata_i
//
// One request per cycle. Between a request and its result lie the map read, the
// four-bank sample read and the two interpolation multipliers, each behind its own
// register.
// busy stays low: the pipeline never stops and results cannot be held off.
// Reset clears valid bits and configuration; map and samples keep no reset.
module tiled_grid_triangle_interpolator import tgti_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  logic               world_i,
  input  logic [31:0]        pos_x_i,
  input  logic [31:0]        pos_y_i,
  input  logic [18:0]        load_address_i,
  input  logic [15:0]        load_value_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               valid_o,
  output logic               found_o,
  output logic [15:0]        temperature_o,
  output logic [2:0]         status_o
);

  // configuration
  logic [WORLDS-1:0][15:0] origin_x_q, origin_y_q;
  logic [WORLDS-1:0][12:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      width_q    <= '0;
      height_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i[1:0])
        REG_ORIGIN_X: origin_x_q[cfg_index_i[2]] <= cfg_wdata_i;
        REG_ORIGIN_Y: origin_y_q[cfg_index_i[2]] <= cfg_wdata_i;
        REG_WIDTH:    width_q[cfg_index_i[2]]    <= cfg_wdata_i[12:0];
        REG_HEIGHT:   height_q[cfg_index_i[2]]   <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid bits
  logic [9:1] v_q, v_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_comb begin
    v_d    = {v_q[8:1], start & ~busy};
  end

  // stage 1: capture request
  logic [1:0]  act1_q;
  logic        w1_q;
  logic [31:0] x1_q, y1_q;
  logic [18:0] la1_q;
  logic [15:0] lv1_q;

  always_ff @(posedge clk_i) begin
    act1_q <= action_i;
    w1_q   <= world_i;
    x1_q   <= pos_x_i;
    y1_q   <= pos_y_i;
    la1_q  <= load_address_i;
    lv1_q  <= load_value_i;
  end

  // stage 1 logic: grid offset, early status, slot estimate
  logic [15:0] ox1, oy1;
  logic [12:0] wid1, hgt1;
  logic [16:0] ix1, iy1;
  logic [30:0] p1;
  logic [2:0]  st1;

  always_comb begin
    ox1  = origin_x_q[w1_q];
    oy1  = origin_y_q[w1_q];
    wid1 = width_q[w1_q];
    hgt1 = height_q[w1_q];
    ix1  = {x1_q[31], x1_q[31:16]} - {ox1[15], ox1};
    iy1  = {y1_q[31], y1_q[31:16]} - {oy1[15], oy1};
    p1   = 31'(la1_q * 12'(RECIP_CELL));
    st1  = ST_OK;
    case (act1_q)
      ACT_QUERY:  if (wid1 == '0) st1 = ST_NOT_READY;
      ACT_MAP:    if (la1_q[18:12] != '0 || (!lv1_q[15] && lv1_q[14:8] != '0))
                    st1 = ST_REJECT;
      ACT_SAMPLE: if (la1_q >= 19'(SAMPLE_LIMIT)) st1 = ST_REJECT;
      default:    st1 = ST_REJECT;
    endcase
  end

  // stage 2
  logic [1:0]  act2_q;
  logic        w2_q;
  logic [2:0]  st2_q;
  logic [16:0] ix2_q, iy2_q;
  logic [12:0] wid2_q, hgt2_q;
  logic [15:0] fx2_q, fy2_q, lv2_q;
  logic [18:0] la2_q;
  logic [8:0]  q2_q;

  always_ff @(posedge clk_i) begin
    act2_q <= act1_q;
    w2_q   <= w1_q;
    st2_q  <= st1;
    ix2_q  <= ix1;
    iy2_q  <= iy1;
    wid2_q <= wid1;
    hgt2_q <= hgt1;
    fx2_q  <= x1_q[15:0];
    fy2_q  <= y1_q[15:0];
    lv2_q  <= lv1_q;
    la2_q  <= la1_q;
    q2_q   <= p1[30:22];
  end

  // stage 2 logic: range check, square index, slot product
  logic        outside2;
  logic [2:0]  st2;
  logic [26:0] sq2;
  logic [19:0] m2;

  always_comb begin
    outside2 = ix2_q[16] || iy2_q[16] || ix2_q >= {4'd0, wid2_q}
            || iy2_q >= {4'd0, hgt2_q};
    st2 = st2_q;
    if (act2_q == ACT_QUERY && st2_q == ST_OK && outside2) st2 = ST_OUTSIDE;
    sq2 = 27'(iy2_q[12:0] * wid2_q) + 27'(ix2_q[12:0]);
    m2  = 20'(q2_q * 11'(CELL_SIZE));
  end

  // stage 3
  logic [1:0]  act3_q;
  logic        w3_q;
  logic [2:0]  st3_q;
  logic [26:0] sq3_q;
  logic [15:0] fx3_q, fy3_q, lv3_q;
  logic [18:0] la3_q;
  logic [8:0]  q3_q;
  logic [19:0] m3_q;

  always_ff @(posedge clk_i) begin
    act3_q <= act2_q;
    w3_q   <= w2_q;
    st3_q  <= st2;
    sq3_q  <= sq2;
    fx3_q  <= fx2_q;
    fy3_q  <= fy2_q;
    lv3_q  <= lv2_q;
    la3_q  <= la2_q;
    q3_q   <= q2_q;
    m3_q   <= m2;
  end

  // stage 3 logic: map access, slot correction
  logic [2:0]        st3;
  logic [MAP_AW-1:0] map_addr3;
  logic              map_we3;
  logic [11:0]       r3raw;
  logic [7:0]        slot3;
  logic [10:0]       r3;

  always_comb begin
    st3 = st3_q;
    if (act3_q == ACT_QUERY && st3_q == ST_OK && sq3_q[26:12] != '0) st3 = ST_NO_CELL;
    map_addr3 = (act3_q == ACT_QUERY) ? {w3_q, sq3_q[11:0]} : {w3_q, la3_q[11:0]};
    map_we3   = v_q[3] && act3_q == ACT_MAP && st3_q == ST_OK;
    r3raw     = 12'(la3_q - m3_q[18:0]);
    if (r3raw >= 12'(CELL_SIZE)) begin
      slot3 = 8'(q3_q + 9'd1);
      r3    = 11'(r3raw - 12'(CELL_SIZE));
    end else begin
      slot3 = q3_q[7:0];
      r3    = r3raw[10:0];
    end
  end

  // slot map: empty flag over slot number
  logic [8:0] slot_map [MAP_DEPTH];
  logic [8:0] map_rd_q;

  always_ff @(posedge clk_i) begin
    if (map_we3) begin
      slot_map[map_addr3] <= {lv3_q[15], lv3_q[7:0]};
    end
    map_rd_q <= slot_map[map_addr3];
  end

  // stage 4
  logic        qry4_q, smp4_q;
  logic        w4_q;
  logic [2:0]  st4_q;
  logic [15:0] fx4_q, fy4_q, lv4_q;
  logic [7:0]  slot4_q;
  logic [10:0] r4_q;

  always_ff @(posedge clk_i) begin
    qry4_q  <= act3_q == ACT_QUERY;
    smp4_q  <= act3_q == ACT_SAMPLE;
    w4_q    <= w3_q;
    st4_q   <= st3;
    fx4_q   <= fx3_q;
    fy4_q   <= fy3_q;
    lv4_q   <= lv3_q;
    slot4_q <= slot3;
    r4_q    <= r3;
  end

  // stage 4 logic: empty check, row and column of a load
  logic [2:0]  st4;
  logic [21:0] rp4;
  logic [5:0]  rq4;
  logic [10:0] rr4;
  logic [5:0]  row4, col4;
  logic [8:0]  cell4;

  always_comb begin
    st4 = st4_q;
    if (qry4_q && st4_q == ST_OK && map_rd_q[8]) st4 = ST_NO_CELL;
    rp4 = 22'(r4_q * 11'(RECIP_SIDE));
    rq4 = rp4[21:16];
    rr4 = r4_q - 11'({rq4, 5'd0}) - 11'(rq4);
    if (rr4 >= 11'd33) begin
      row4 = rq4 + 6'd1;
      col4 = 6'(rr4 - 11'd33);
    end else begin
      row4 = rq4;
      col4 = rr4[5:0];
    end
    if (qry4_q) begin
      cell4 = {w4_q, map_rd_q[7:0]};
    end else begin
      cell4 = {w4_q, slot4_q};
    end
  end

  // stage 5
  logic        qry5_q, smp5_q;
  logic [2:0]  st5_q;
  logic [8:0]  cell5_q;
  logic [4:0]  rb5_q, cb5_q;
  logic        rodd5_q, codd5_q;
  logic [1:0]  bsel5_q;
  logic [10:0] fu5_q, fv5_q;
  logic [15:0] lv5_q;

  always_ff @(posedge clk_i) begin
    qry5_q  <= qry4_q;
    smp5_q  <= smp4_q;
    st5_q   <= st4;
    cell5_q <= cell4;
    if (qry4_q) begin
      rb5_q   <= {1'b0, fy4_q[15:12]};
      cb5_q   <= {1'b0, fx4_q[15:12]};
      rodd5_q <= fy4_q[11];
      codd5_q <= fx4_q[11];
    end else begin
      rb5_q   <= row4[5:1];
      cb5_q   <= col4[5:1];
      rodd5_q <= 1'b0;
      codd5_q <= 1'b0;
    end
    bsel5_q <= {row4[0], col4[0]};
    fu5_q   <= fx4_q[10:0];
    fv5_q   <= fy4_q[10:0];
    lv5_q   <= lv4_q;
  end

  // stage 5 logic: bank addresses
  logic [BANK_AW-1:0]              cbase5;
  logic [BANKS-1:0][BANK_AW-1:0]   addr5;
  logic [BANKS-1:0]                we5;
  logic [4:0]                      ridx5, cidx5;

  always_comb begin
    cbase5 = BANK_AW'(cell5_q * 9'(BANK_CELL));
    for (int b = 0; b < BANKS; b++) begin
      ridx5    = rb5_q + 5'(rodd5_q & ~b[1]);
      cidx5    = cb5_q + 5'(codd5_q & ~b[0]);
      addr5[b] = cbase5 + BANK_AW'(ridx5 * 5'(HALF_SIDE)) + BANK_AW'(cidx5);
      we5[b]   = v_q[5] && smp5_q && st5_q == ST_OK && bsel5_q == 2'(b);
    end
  end

  // stage 6
  logic        qry6_q;
  logic [2:0]  st6_q;
  logic [BANKS-1:0][BANK_AW-1:0] addr6_q;
  logic [BANKS-1:0] we6_q;
  logic [15:0] wd6_q;
  logic [10:0] fu6_q, fv6_q;
  logic        rodd6_q, codd6_q;

  always_ff @(posedge clk_i) begin
    qry6_q  <= qry5_q;
    st6_q   <= st5_q;
    addr6_q <= addr5;
    we6_q   <= we5;
    wd6_q   <= lv5_q;
    fu6_q   <= fu5_q;
    fv6_q   <= fv5_q;
    rodd6_q <= rodd5_q;
    codd6_q <= codd5_q;
  end

  logic [BANKS-1:0][15:0] rdata7;

  tgti_sample_banks u_banks (
    .clk_i   (clk_i),
    .we_i    (we6_q),
    .addr_i  (addr6_q),
    .wdata_i (wd6_q),
    .rdata_o (rdata7)
  );

  // stage 7
  logic        qry7_q;
  logic [2:0]  st7_q;
  logic [10:0] fu7_q, fv7_q;
  logic        rodd7_q, codd7_q;

  always_ff @(posedge clk_i) begin
    qry7_q  <= qry6_q;
    st7_q   <= st6_q;
    fu7_q   <= fu6_q;
    fv7_q   <= fv6_q;
    rodd7_q <= rodd6_q;
    codd7_q <= codd6_q;
  end

  // stage 7 logic: pick triangle, edge products
  logic [15:0] t00, t10, t01, t11, base7;
  logic [16:0] da7, db7;
  logic [11:0] wa7, wb7;
  logic        lower7;
  logic signed [29:0] pa7, pb7;

  always_comb begin
    t00 = rdata7[{rodd7_q, codd7_q}];
    t10 = rdata7[{rodd7_q, ~codd7_q}];
    t01 = rdata7[{~rodd7_q, codd7_q}];
    t11 = rdata7[{~rodd7_q, ~codd7_q}];
    lower7 = (12'(fu7_q) + 12'(fv7_q)) <= 12'd2048;
    if (lower7) begin
      base7 = t00;
      da7   = {t10[15], t10} - {t00[15], t00};
      db7   = {t01[15], t01} - {t00[15], t00};
      wa7   = 12'(fu7_q);
      wb7   = 12'(fv7_q);
    end else begin
      base7 = t11;
      da7   = {t01[15], t01} - {t11[15], t11};
      db7   = {t10[15], t10} - {t11[15], t11};
      wa7   = 12'd2048 - 12'(fu7_q);
      wb7   = 12'd2048 - 12'(fv7_q);
    end
    pa7 = 30'($signed(da7) * $signed({1'b0, wa7}));
    pb7 = 30'($signed(db7) * $signed({1'b0, wb7}));
  end

  // stage 8
  logic        found8_q;
  logic [2:0]  st8_q;
  logic [15:0] base8_q;
  logic [29:0] pa8_q, pb8_q;

  always_ff @(posedge clk_i) begin
    found8_q <= qry7_q && st7_q == ST_OK;
    st8_q    <= st7_q;
    base8_q  <= base7;
    pa8_q    <= pa7;
    pb8_q    <= pb7;
  end

  // stage 8 logic: sum and round half up
  logic [32:0] sum8;

  always_comb begin
    sum8 = {{6{base8_q[15]}}, base8_q, 11'd0} + {{3{pa8_q[29]}}, pa8_q}
         + {{3{pb8_q[29]}}, pb8_q} + 33'd1024;
  end

  // result register
  logic        found_q;
  logic [15:0] temp_q;
  logic [2:0]  status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      temp_q   <= '0;
      status_q <= ST_OK;
    end else begin
      found_q  <= v_q[8] && found8_q;
      temp_q   <= found8_q ? sum8[26:11] : 16'd0;
      status_q <= st8_q;
    end
  end

  assign valid_o       = v_q[9];
  assign found_o       = found_q;
  assign temperature_o = temp_q;
  assign status_o      = status_q;

`include "tiled_grid_triangle_interpolator_assert.svh"

  `TGTI_ASSERT(a_result_follows_request, start && !busy |-> ##(LATENCY + 1) valid_o)
  `TGTI_ASSERT(a_found_means_ok, valid_o && found_o |-> status_o == ST_OK)
  `TGTI_ASSERT(a_missing_reads_zero, valid_o && !found_o |-> temperature_o == 16'd0)
  `TGTI_ASSERT_ALWAYS(a_no_stray_found, !valid_o |-> !found_o)

endmodule

// ===== sv/tgti_sample_banks.sv =====
// Four sample banks split by row and column parity, registered reads
module tgti_sample_banks import tgti_pkg::*; (
  input  logic                             clk_i,
  input  logic [BANKS-1:0]                 we_i,
  input  logic [BANKS-1:0][BANK_AW-1:0]    addr_i,
  input  logic [15:0]                      wdata_i,
  output logic [BANKS-1:0][15:0]           rdata_o
);

  logic [BANKS-1:0][15:0] rdata_q;

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [15:0] mem [BANK_DEPTH];

    // read one entry per bank each cycle, writing it as well when enabled
    always_ff @(posedge clk_i) begin
      if (we_i[b]) begin
        mem[addr_i[b]] <= wdata_i;
      end
      rdata_q[b] <= mem[addr_i[b]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the tiled grid triangle interpolator: self-predicting random regression
`timescale 1ns / 1ps

module tb_top;
  import tgti_pkg::*;

  typedef struct {
    logic [1:0]  act;
    logic        wld;
    logic [31:0] px;
    logic [31:0] py;
    logic [18:0] addr;
    logic [15:0] val;
    logic        found;
    logic [15:0] temp;
    logic [2:0]  st;
  } request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action_i = ACT_QUERY;
  logic        world_i = 1'b0;
  logic [31:0] pos_x_i = '0;
  logic [31:0] pos_y_i = '0;
  logic [18:0] load_address_i = '0;
  logic [15:0] load_value_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        valid_o;
  logic        found_o;
  logic [15:0] temperature_o;
  logic [2:0]  status_o;

  tiled_grid_triangle_interpolator dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow of the block's tables and registers
  int                 slot_of[int];
  logic [15:0]        heat_of[int];
  logic signed [15:0] org_x[2];
  logic signed [15:0] org_y[2];
  logic [12:0]        cols[2];
  logic [12:0]        rows[2];

  request_t pending_q[$];
  request_t answer_q[$];
  request_t cur;
  int       errors = 0;
  int       gap = 0;
  bit       calm = 1'b0;

  task automatic flag(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // compute the answer and update the shadow; 0 when a query would read unwritten data
  function automatic bit forecast(inout request_t r);
    longint ix, iy, sq, t00, t10, t01, t11, sum;
    int     w, slot, key, fi, fj, fu, fv, base;
    w = r.wld;
    r.found = 1'b0;
    r.temp = '0;
    r.st = ST_OK;
    case (r.act)
      ACT_QUERY: begin
        ix = longint'($signed(r.px) >>> 16) - longint'(org_x[w]);
        iy = longint'($signed(r.py) >>> 16) - longint'(org_y[w]);
        if (cols[w] == 0) begin
          r.st = ST_NOT_READY;
        end else if (ix < 0 || iy < 0 || ix >= longint'(cols[w]) ||
                     iy >= longint'(rows[w])) begin
          r.st = ST_OUTSIDE;
        end else begin
          sq = iy * longint'(cols[w]) + ix;
          if (sq >= longint'(MAX_SQUARES)) begin
            r.st = ST_NO_CELL;
          end else begin
            key = w * MAX_SQUARES + int'(sq);
            if (!slot_of.exists(key)) return 1'b0;
            slot = slot_of[key];
            if (slot < 0) begin
              r.st = ST_NO_CELL;
            end else begin
              fi = r.px[15:11];
              fj = r.py[15:11];
              fu = r.px[10:0];
              fv = r.py[10:0];
              base = w * SAMPLE_LIMIT + slot * CELL_SIZE + fj * 33 + fi;
              if (!heat_of.exists(base) || !heat_of.exists(base + 1) ||
                  !heat_of.exists(base + 33) || !heat_of.exists(base + 34)) return 1'b0;
              t00 = longint'($signed(heat_of[base]));
              t10 = longint'($signed(heat_of[base + 1]));
              t01 = longint'($signed(heat_of[base + 33]));
              t11 = longint'($signed(heat_of[base + 34]));
              if (fu + fv <= 2048)
                sum = t00 * 2048 + (t10 - t00) * fu + (t01 - t00) * fv;
              else
                sum = t11 * 2048 + (t01 - t11) * (2048 - fu) + (t10 - t11) * (2048 - fv);
              sum = (sum + 1024) >>> 11;
              r.temp = sum[15:0];
              r.found = 1'b1;
            end
          end
        end
      end
      ACT_MAP: begin
        if (r.addr >= MAX_SQUARES || int'($signed(r.val)) >= int'(MAX_CELLS)) begin
          r.st = ST_REJECT;
        end else begin
          slot_of[w * MAX_SQUARES + r.addr] = ($signed(r.val) < 0) ? -1 : int'(r.val);
        end
      end
      ACT_SAMPLE: begin
        if (r.addr >= SAMPLE_LIMIT) r.st = ST_REJECT;
        else heat_of[w * SAMPLE_LIMIT + r.addr] = r.val;
      end
      default: r.st = ST_REJECT;
    endcase
    return 1'b1;
  endfunction

  task automatic add(logic [1:0] act, int w, logic [31:0] px, logic [31:0] py,
                     logic [18:0] addr, logic [15:0] val);
    request_t r;
    r.act = act;
    r.wld = w[0];
    r.px = px;
    r.py = py;
    r.addr = addr;
    r.val = val;
    if (forecast(r)) pending_q.push_back(r);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // query one square, first loading its map entry and four corner samples when unset or at random
  task automatic probe(int w, int c, int r, logic [15:0] fx, logic [15:0] fy);
    int         key, slot, base;
    logic [15:0] sx, sy;
    sx = 16'(int'(org_x[w]) + c);
    sy = 16'(int'(org_y[w]) + r);
    key = w * MAX_SQUARES + r * int'(cols[w]) + c;
    if (cols[w] != 0 && r < rows[w] && r * int'(cols[w]) + c < MAX_SQUARES) begin
      if (!slot_of.exists(key) || $urandom_range(0, 19) == 0) begin
        slot = ($urandom_range(0, 9) == 0) ? -1 :
               ($urandom_range(0, 5) == 0) ? MAX_CELLS - 1 : $urandom_range(0, MAX_CELLS - 1);
        add(ACT_MAP, w, '0, '0, 19'(key - w * MAX_SQUARES), 16'(slot));
      end
      slot = slot_of[key];
      if (slot >= 0) begin
        base = slot * CELL_SIZE + fy[15:11] * 33 + fx[15:11];
        for (int k = 0; k < 4; k++) begin
          int off;
          off = (k == 0) ? 0 : (k == 1) ? 1 : (k == 2) ? 33 : 34;
          if (!heat_of.exists(w * SAMPLE_LIMIT + base + off) || $urandom_range(0, 9) == 0)
            add(ACT_SAMPLE, w, '0, '0, 19'(base + off), pick_sample());
        end
      end
    end
    add(ACT_QUERY, w, {sx, fx}, {sy, fy}, '0, '0);
  endtask

  function automatic logic [15:0] pick_frac();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return {5'($urandom), 11'd1024};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(int w, logic [1:0] sel, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= {w[0], sel};
    cfg_wdata_i <= data;
    case (sel)
      REG_ORIGIN_X: org_x[w] = data;
      REG_ORIGIN_Y: org_y[w] = data;
      REG_WIDTH:    cols[w] = data[12:0];
      default:      rows[w] = data[12:0];
    endcase
  endtask

  task automatic setup(int w, int ox, int oy, int wd, int ht);
    write_reg(w, REG_ORIGIN_X, 16'(ox));
    write_reg(w, REG_ORIGIN_Y, 16'(oy));
    write_reg(w, REG_WIDTH, 16'(wd));
    write_reg(w, REG_HEIGHT, 16'(ht));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !start && answer_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // mostly well-formed queries with loads in front, plus noise
  task automatic random_phase(int events);
    int w, c, r, lim;
    for (int n = 0; n < events; n++) begin
      w = $urandom_range(0, 1);
      case ($urandom_range(0, 19))
        0, 1: add(ACT_QUERY, w, $urandom, $urandom, '0, '0);
        2, 3: add(ACT_SAMPLE, w, '0, '0,
                  ($urandom_range(0, 3) == 0) ? 19'($urandom) : 19'($urandom_range(0, 278783)),
                  16'($urandom));
        4: add(ACT_MAP, w, '0, '0, 19'($urandom_range(0, 8191)),
               ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300)));
        5: add(2'd3, w, $urandom, $urandom, 19'($urandom), 16'($urandom));
        6: probe(w, int'(cols[w]) + $urandom_range(0, 3), $urandom_range(0, 3),
                 pick_frac(), pick_frac());
        default: begin
          if (cols[w] == 0 || rows[w] == 0) begin
            probe(w, 0, 0, pick_frac(), pick_frac());
          end else begin
            lim = MAX_SQUARES / int'(cols[w]);
            if (lim > int'(rows[w]) || $urandom_range(0, 7) == 0) lim = rows[w];
            if (lim < 1) lim = 1;
            c = $urandom_range(0, int'(cols[w]) - 1);
            r = $urandom_range(0, lim - 1);
            probe(w, c, r, pick_frac(), pick_frac());
          end
        end
      endcase
    end
  endtask

  // drive requests: hold while busy, then issue the next one after a random gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap = 0;
    end else if (!start || !busy) begin
      if (start) answer_q.push_back(cur);
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur = pending_q.pop_front();
        action_i <= cur.act;
        world_i <= cur.wld;
        pos_x_i <= cur.px;
        pos_y_i <= cur.py;
        load_address_i <= cur.addr;
        load_value_i <= cur.val;
        start <= 1'b1;
        if (calm) gap = 0;
        else if ($urandom_range(0, 9) < 6) gap = 0;
        else if ($urandom_range(0, 9) < 9) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // check each result against the oldest expectation
  always @(posedge clk_i) begin
    request_t e;
    if (rst_ni && valid_o) begin
      if (answer_q.size() == 0) begin
        flag("unexpected result", {13'd0, status_o}, '0);
      end else begin
        e = answer_q.pop_front();
        if (found_o !== e.found) flag("found", {15'd0, found_o}, {15'd0, e.found});
        if (temperature_o !== e.temp) flag("temperature", temperature_o, e.temp);
        if (status_o !== e.st) flag("status", {13'd0, status_o}, {13'd0, e.st});
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    for (int w = 0; w < 2; w++) begin
      org_x[w] = '0;
      org_y[w] = '0;
      cols[w] = '0;
      rows[w] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: no world ready, loads still land
    add(ACT_QUERY, 0, 32'h0, 32'h0, '0, '0);
    add(ACT_QUERY, 1, 32'h7fffffff, 32'h80000000, '0, '0);
    add(ACT_SAMPLE, 0, '0, '0, 19'd278783, 16'h7fff);
    drain();

    setup(0, 0, 0, 8, 8);
    setup(1, -32768, 32767, 4096, 1);
    // directed: rejects, empty entry, triangle edges, grid edges
    add(2'd3, 0, '1, '1, '1, '1);
    add(ACT_MAP, 0, '0, '0, 19'd4096, 16'd1);
    add(ACT_MAP, 1, '0, '0, 19'h7ffff, 16'd0);
    add(ACT_MAP, 0, '0, '0, 19'd1, 16'd256);
    add(ACT_MAP, 0, '0, '0, 19'd1, 16'h7fff);
    add(ACT_SAMPLE, 0, '0, '0, 19'd278784, 16'd5);
    add(ACT_SAMPLE, 1, '0, '0, 19'h7ffff, 16'd5);
    add(ACT_MAP, 0, '0, '0, 19'd0, 16'h8000);
    add(ACT_QUERY, 0, 32'h0000_1234, 32'h0000_4321, '0, '0);
    probe(0, 7, 7, 16'hffff, 16'hffff);
    probe(0, 3, 2, 16'h0400, 16'h0400);
    probe(0, 1, 1, 16'h0401, 16'h03ff);
    probe(0, 5, 0, 16'h0000, 16'h0000);
    probe(1, 4095, 0, 16'hf800, 16'h07ff);
    probe(1, 0, 0, 16'h07ff, 16'hf801);
    add(ACT_QUERY, 0, 32'hffff_ffff, 32'h0, '0, '0);
    add(ACT_QUERY, 0, 32'h0, 32'h0008_0000, '0, '0);
    add(ACT_QUERY, 1, 32'h8000_0000, 32'h7ffe_ffff, '0, '0);
    random_phase(40);
    drain();

    setup(0, 32764, -32768, 4, 4096);
    setup(1, 100, -100, 5, 0);
    calm = 1'b1;
    random_phase(20);
    drain();
    calm = 1'b0;
    random_phase(20);
    drain();

    setup(0, 7, 7, 0, 10);
    setup(1, int'($urandom_range(0, 60000)) - 30000, int'($urandom_range(0, 60000)) - 30000,
          16, 16);
    random_phase(45);
    drain();

    setup(0, -32768, 32752, 16, 16);
    setup(1, 32767, 0, 1, 4096);
    random_phase(40);
    drain();

    if (errors == 0 && answer_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // guard against a hang
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== tiled_grid_triangle_interpolator.f =====
+incdir+sv
sv/tgti_pkg.sv
sv/tgti_sample_banks.sv
sv/tiled_grid_triangle_interpolator.sv
bench/tb_top.sv
